FILE: sv/parity_keyed_sorter_assert.svh
// Assertion macros for the parity keyed sorter.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef PARITY_KEYED_SORTER_ASSERT_SVH
`define PARITY_KEYED_SORTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PKS_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PKS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/pks_pkg.sv
// Package for the parity keyed sorter: default sizes, control types, states.
// No dependencies.
package pks_pkg;

    localparam int PKS_CAPACITY   = 16;
    localparam int PKS_DATA_WIDTH = 32;

    // Per-cycle command broadcast to every cell of the chain.
    typedef struct packed {
        logic load;   // insert the incoming word into the sorted row
        logic shift;  // move every word one cell toward the output
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        ST_LOAD  = 2'b01,
        ST_DRAIN = 2'b10
    } state_t;

endpackage

FILE: sv/pks_if.sv
// Handshake channels of the parity keyed sorter: input words and sorted results.
// Depends on pks_pkg for the default data width.
interface pks_in_if
    import pks_pkg::*;
#(
    parameter int DATA_WIDTH = PKS_DATA_WIDTH
);
    logic                  valid;
    logic                  ready;
    logic [DATA_WIDTH-1:0] value;
    logic                  last_in;

    modport source (output valid, output value, output last_in, input ready);
    modport sink   (input valid, input value, input last_in, output ready);
endinterface

interface pks_out_if
    import pks_pkg::*;
#(
    parameter int DATA_WIDTH = PKS_DATA_WIDTH
);
    logic                  valid;
    logic                  ready;
    logic [DATA_WIDTH-1:0] sorted_value;
    logic                  last_out;
    logic                  overflow;

    modport source (output valid, output sorted_value, output last_out, output overflow,
                    input ready);
    modport sink   (input valid, input sorted_value, input last_out, input overflow,
                    output ready);
endinterface

FILE: sv/pks_cell.sv
// One cell of the sorting chain: holds one word and its valid bit.
// Depends on pks_pkg for cell_ctrl_t.
module pks_cell
    import pks_pkg::*;
#(
    parameter int DATA_WIDTH = PKS_DATA_WIDTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cell_ctrl_t            ctrl,
    input  logic [DATA_WIDTH-1:0] new_data,
    input  logic                  left_valid,
    input  logic                  left_ins,
    input  logic [DATA_WIDTH-1:0] left_data,
    input  logic                  right_valid,
    input  logic [DATA_WIDTH-1:0] right_data,
    output logic                  valid,
    output logic                  ins,
    output logic [DATA_WIDTH-1:0] data
);

    logic                  valid_reg;
    logic                  valid_next;
    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;
    logic                  new_first;

    // Even words come before odd words; within one parity, ascending signed order.
    always_comb
    begin
        if (new_data[0] != data_reg[0])
        begin
            new_first = !new_data[0];
        end
        else
        begin
            new_first = $signed(new_data) < $signed(data_reg);
        end
    end

    assign ins = !valid_reg || new_first;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        priority if (ctrl.shift)
        begin
            valid_next = right_valid;
            data_next  = right_data;
        end
        else if (ctrl.load && ins)
        begin
            valid_next = valid_reg || left_valid;
            data_next  = left_ins ? left_data : new_data;
        end
        else
        begin
            valid_next = valid_reg;
            data_next  = data_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

FILE: sv/parity_keyed_sorter.sv
// Parity keyed sorter: top level with the cell chain and its load/drain control.
// Depends on pks_pkg, pks_if, pks_cell and parity_keyed_sorter_assert.svh.
// Loading takes one word per cycle; each accepted word that finds the row not full
// is placed in the sorted row in the cycle it is accepted. The first result is offered
// in the cycle after the word marked last is accepted, then one result per cycle while
// the sink takes them. No word is accepted while a set drains. Reset clears the cell
// valid bits, state and overflow flag at once.
`include "parity_keyed_sorter_assert.svh"

module parity_keyed_sorter
    import pks_pkg::*;
#(
    parameter int CAPACITY   = PKS_CAPACITY,
    parameter int DATA_WIDTH = PKS_DATA_WIDTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    pks_in_if.sink    in_ch,
    pks_out_if.source out_ch
);

    // The row of cells holds the current set in sorted order, cell 0 at the head.
    // Valid cells always form a prefix of the row, so the last cell's valid bit
    // doubles as the "store full" flag and no separate counter is needed.
    state_t                state_reg;
    state_t                state_next;
    logic                  overflow_reg;
    logic                  overflow_next;
    cell_ctrl_t            ctrl;
    logic                  in_fire;
    logic                  out_fire;
    logic                  full;
    logic                  valid_prefix_ok;
    logic [CAPACITY-1:0]   valid_vec;
    logic [CAPACITY-1:0]   ins_vec;
    logic [DATA_WIDTH-1:0] cell_data [CAPACITY];

    assign full     = valid_vec[CAPACITY-1];
    assign in_fire  = in_ch.valid && in_ch.ready;
    assign out_fire = out_ch.valid && out_ch.ready;

    // A word that arrives with the row full is dropped, as the set is truncated.
    assign ctrl.load  = in_fire && !full;
    assign ctrl.shift = out_fire;

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic                  left_valid;
            logic                  left_ins;
            logic [DATA_WIDTH-1:0] left_data;
            logic                  right_valid;
            logic [DATA_WIDTH-1:0] right_data;

            // The head cell sees a valid, non-displaced neighbor on its left so that
            // it takes the incoming word whenever that word belongs in front.
            if (i == 0)
            begin : g_head
                assign left_valid = 1'b1;
                assign left_ins   = 1'b0;
                assign left_data  = '0;
            end
            else
            begin : g_body
                assign left_valid = valid_vec[i-1];
                assign left_ins   = ins_vec[i-1];
                assign left_data  = cell_data[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_tail
                assign right_valid = 1'b0;
                assign right_data  = '0;
            end
            else
            begin : g_next
                assign right_valid = valid_vec[i+1];
                assign right_data  = cell_data[i+1];
            end

            pks_cell #(
                .DATA_WIDTH (DATA_WIDTH)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .new_data    (in_ch.value),
                .left_valid  (left_valid),
                .left_ins    (left_ins),
                .left_data   (left_data),
                .right_valid (right_valid),
                .right_data  (right_data),
                .valid       (valid_vec[i]),
                .ins         (ins_vec[i]),
                .data        (cell_data[i])
            );
        end
    endgenerate

    // Control: collect words until the one marked last, then drain the row.
    always_comb
    begin
        state_next    = state_reg;
        overflow_next = overflow_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_fire)
                begin
                    if (full)
                    begin
                        overflow_next = 1'b1;
                    end
                    if (in_ch.last_in)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                if (out_fire && out_ch.last_out)
                begin
                    state_next    = ST_LOAD;
                    overflow_next = 1'b0;
                end
            end
            default:
            begin
                state_next    = ST_LOAD;
                overflow_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            overflow_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            overflow_reg <= overflow_next;
        end
    end

    // Results come straight from the head cell, which is itself a register.
    // The final word of the set is the one with no valid word behind it.
    assign in_ch.ready         = (state_reg == ST_LOAD);
    assign out_ch.valid        = (state_reg == ST_DRAIN) && valid_vec[0];
    assign out_ch.sorted_value = cell_data[0];
    assign out_ch.last_out     = !valid_vec[1];
    assign out_ch.overflow     = overflow_reg;

    assign valid_prefix_ok = ((valid_vec + CAPACITY'(1)) & valid_vec) == '0;

    `PKS_ASSERT_IMPLY(a_no_overlap, in_ch.ready, !out_ch.valid,
                      "input accepted while results are offered")
    `PKS_ASSERT_NEXT(a_drain_starts, in_fire && in_ch.last_in, out_ch.valid,
                     "no result offered after the closing word")
    `PKS_ASSERT_NEXT(a_overflow_set, in_fire && full && !in_ch.last_in, overflow_reg,
                     "word dropped on a full row without raising overflow")
    `PKS_ASSERT_NEXT(a_empty_after_set, out_fire && out_ch.last_out,
                     in_ch.ready && !valid_vec[0],
                     "row not empty after the final result")
    `PKS_ASSERT_IMPLY(a_valid_prefix, 1'b1, valid_prefix_ok,
                      "valid cells do not form a prefix of the row")

endmodule
